// File: sv/uwbr_pkg.sv
// Shared widths, codes and record types of the UWB ranging initiator round.
package uwbr_pkg;

  localparam int TS_W            = 40;
  localparam int ADDR_W          = 16;
  localparam int SEQ_W           = 8;
  localparam int KIND_W          = 8;
  localparam int TOTAL_W         = 32;
  localparam int FINAL_W         = TS_W + 1;
  localparam int SCHED_SHIFT     = 8;
  localparam int BASE_LSB        = SCHED_SHIFT + 1;
  localparam int BASE_W          = TS_W - BASE_LSB;
  localparam int ANCHORS         = 3;
  localparam int SLOT_W          = $clog2(ANCHORS + 1);
  localparam int CFG_IDX_W       = 3;
  localparam int CFG_DATA_W      = 40;
  localparam int DEF_QUEUE_DEPTH = 2;

  typedef enum logic {
    CMD_POLL = 1'b0,
    CMD_SLOT = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    RX_FRAME   = 2'd0,
    RX_TIMEOUT = 2'd1,
    RX_ERROR   = 2'd2
  } rx_status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MY_ADDRESS     = 3'd0,
    REG_ANCHOR_ONE     = 3'd1,
    REG_ANCHOR_TWO     = 3'd2,
    REG_ANCHOR_THREE   = 3'd3,
    REG_RESPONSE_TYPE  = 3'd4,
    REG_FINAL_DELAY    = 3'd5,
    REG_ANTENNA_DELAY  = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [ADDR_W-1:0]              my_address;
    logic [ANCHORS-1:0][ADDR_W-1:0] anchor_id;
    logic [KIND_W-1:0]              response_type;
    logic [TS_W-1:0]                final_delay;
    logic [ADDR_W-1:0]              antenna_delay;
  } cfg_t;

  typedef struct packed {
    cmd_t               cmd;
    logic               send_ok;
    logic [TS_W-1:0]    poll_time;
    logic [BASE_W-1:0]  final_base;
    logic               frame_ok;
    logic [SEQ_W-1:0]   seq;
    logic [ANCHORS-1:0] hit;
    logic [TS_W-1:0]    rx_time;
  } q_entry_t;

  typedef struct packed {
    logic [SEQ_W-1:0]               round_seq;
    logic [TS_W-1:0]                poll_stamp;
    logic [FINAL_W-1:0]             final_stamp;
    logic [ANCHORS-1:0][ADDR_W-1:0] slot_addr;
    logic [ANCHORS-1:0][TS_W-1:0]   slot_rx;
    logic [TOTAL_W-1:0]             ok_rounds;
    logic [TOTAL_W-1:0]             lost_rounds;
  } result_t;

endpackage

// File: sv/uwbr_if.sv
// Channel interfaces: event input, final record output and register write.
interface uwbr_in_if import uwbr_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic              send_ok;
  logic [TS_W-1:0]   poll_time;
  logic [1:0]        rx_status;
  logic              frame_long_enough;
  logic [KIND_W-1:0] msg_kind;
  logic [SEQ_W-1:0]  msg_seq;
  logic [ADDR_W-1:0] msg_dest;
  logic [ADDR_W-1:0] msg_source;
  logic [TS_W-1:0]   rx_time;

  modport source (
    output valid, cmd, send_ok, poll_time, rx_status, frame_long_enough,
           msg_kind, msg_seq, msg_dest, msg_source, rx_time,
    input  ready
  );
  modport sink (
    input  valid, cmd, send_ok, poll_time, rx_status, frame_long_enough,
           msg_kind, msg_seq, msg_dest, msg_source, rx_time,
    output ready
  );
endinterface

interface uwbr_out_if import uwbr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [SEQ_W-1:0]   round_seq;
  logic [TS_W-1:0]    poll_stamp;
  logic [FINAL_W-1:0] final_stamp;
  logic [ADDR_W-1:0]  slot1_addr;
  logic [TS_W-1:0]    slot1_rx;
  logic [ADDR_W-1:0]  slot2_addr;
  logic [TS_W-1:0]    slot2_rx;
  logic [ADDR_W-1:0]  slot3_addr;
  logic [TS_W-1:0]    slot3_rx;
  logic [TOTAL_W-1:0] ok_rounds;
  logic [TOTAL_W-1:0] lost_rounds;

  modport source (
    output valid, round_seq, poll_stamp, final_stamp, slot1_addr, slot1_rx,
           slot2_addr, slot2_rx, slot3_addr, slot3_rx, ok_rounds, lost_rounds,
    input  ready
  );
  modport sink (
    input  valid, round_seq, poll_stamp, final_stamp, slot1_addr, slot1_rx,
           slot2_addr, slot2_rx, slot3_addr, slot3_rx, ok_rounds, lost_rounds,
    output ready
  );
endinterface

interface uwbr_cfg_if import uwbr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/uwbr_cfg_regs.sv
// Configuration register file written through the register write channel.
module uwbr_cfg_regs import uwbr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  uwbr_cfg_if.sink   cfg_ch,
  output cfg_t       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr_en;

  assign cfg_ch.ready = 1'b1;
  assign wr_en        = cfg_ch.valid && cfg_ch.ready;
  assign cfg          = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (cfg_reg_t'(cfg_ch.index))
        REG_MY_ADDRESS:    cfg_nxt.my_address    = cfg_ch.data[ADDR_W-1:0];
        REG_ANCHOR_ONE:    cfg_nxt.anchor_id[0]  = cfg_ch.data[ADDR_W-1:0];
        REG_ANCHOR_TWO:    cfg_nxt.anchor_id[1]  = cfg_ch.data[ADDR_W-1:0];
        REG_ANCHOR_THREE:  cfg_nxt.anchor_id[2]  = cfg_ch.data[ADDR_W-1:0];
        REG_RESPONSE_TYPE: cfg_nxt.response_type = cfg_ch.data[KIND_W-1:0];
        REG_FINAL_DELAY:   cfg_nxt.final_delay   = cfg_ch.data[TS_W-1:0];
        REG_ANTENNA_DELAY: cfg_nxt.antenna_delay = cfg_ch.data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: sv/uwbr_front.sv
// Front end: accepts events, checks frame headers and matches the anchor.
module uwbr_front import uwbr_pkg::*; (
  uwbr_in_if.sink  in_ch,
  input  cfg_t     cfg,
  input  logic     full,
  output logic     push,
  output q_entry_t entry
);

  logic [TS_W:0]      sched_sum;
  logic [ANCHORS-1:0] hit;
  logic               found;

  assign in_ch.ready = !full;
  assign push        = in_ch.valid && !full;
  assign sched_sum   = {1'b0, in_ch.poll_time} + {1'b0, cfg.final_delay};

  // lowest numbered matching anchor wins
  always_comb begin
    hit   = '0;
    found = 1'b0;
    for (int i = 0; i < ANCHORS; i++) begin
      if (!found && cfg.anchor_id[i] == in_ch.msg_source) begin
        hit[i] = 1'b1;
        found  = 1'b1;
      end
    end
  end

  always_comb begin
    entry.cmd        = cmd_t'(in_ch.cmd);
    entry.send_ok    = in_ch.send_ok;
    entry.poll_time  = in_ch.poll_time;
    entry.final_base = sched_sum[TS_W-1:BASE_LSB];
    entry.frame_ok   = (in_ch.rx_status == RX_FRAME) && in_ch.frame_long_enough &&
                       (in_ch.msg_kind == cfg.response_type) &&
                       (in_ch.msg_dest == cfg.my_address);
    entry.seq        = in_ch.msg_seq;
    entry.hit        = hit;
    entry.rx_time    = in_ch.rx_time;
  end

endmodule

// File: sv/uwbr_queue.sv
// Short FIFO of classified events between front and back end.
module uwbr_queue import uwbr_pkg::*; #(
  parameter int DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  output logic     full,
  input  logic     pop,
  output logic     head_valid,
  output q_entry_t head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  q_entry_t             store_r [DEPTH];
  logic [PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;

  assign full       = count_r == CNT_W'(DEPTH);
  assign head_valid = count_r != '0;
  assign head       = store_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    count_nxt = count_r + CNT_W'(push) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      store_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// File: sv/uwbr_back.sv
// Back end: round state, answer bookkeeping and the final record register.
module uwbr_back import uwbr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  cfg_t     cfg,
  input  logic     head_valid,
  input  q_entry_t head,
  output logic     pop,
  input  logic     out_ready,
  output logic     out_valid,
  output result_t  result
);

  logic [SEQ_W-1:0]             seq_r, seq_nxt;
  logic                         in_round_r, in_round_nxt;
  logic [SLOT_W-1:0]            slot_r, slot_nxt;
  logic [ANCHORS-1:0]           flags_r, flags_nxt;
  logic [SLOT_W-1:0]            cnt_r, cnt_nxt;
  logic [TOTAL_W-1:0]           ok_r, ok_nxt;
  logic [TOTAL_W-1:0]           lost_r, lost_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic [TS_W-1:0]              poll_r;
  logic [BASE_W-1:0]            base_r;
  logic [ANCHORS-1:0][TS_W-1:0] rx_r;
  result_t                      result_r, result_nxt;

  logic [ANCHORS-1:0]  fresh;
  logic                take;
  logic [ANCHORS-1:0]  gain;
  logic [ANCHORS-1:0]  flags_upd;
  logic [SLOT_W-1:0]   cnt_upd;
  logic [SLOT_W-1:0]   slot_upd;
  logic                closing;
  logic                is_slot;
  logic                emit;
  logic                fire;
  logic                answered;
  logic                start_round;
  logic                slot_step;

  assign out_valid = out_valid_r;
  assign result    = result_r;
  assign pop       = fire;

  always_comb begin
    fresh       = head.hit & ~flags_r;
    take        = head.frame_ok && (head.seq == seq_r) && (|fresh);
    gain        = take ? head.hit : '0;
    flags_upd   = flags_r | gain;
    cnt_upd     = cnt_r + SLOT_W'(take);
    slot_upd    = slot_r + SLOT_W'(1);
    closing     = (slot_upd == SLOT_W'(ANCHORS)) || (cnt_upd == SLOT_W'(ANCHORS));
    is_slot     = head.cmd == CMD_SLOT;
    emit        = head_valid && is_slot && in_round_r && closing;
    fire        = head_valid && (!emit || !out_valid_r || out_ready);
    answered    = cnt_upd != '0;
    start_round = fire && !is_slot && head.send_ok;
    slot_step   = fire && is_slot && in_round_r;

    seq_nxt      = seq_r;
    in_round_nxt = in_round_r;
    slot_nxt     = slot_r;
    flags_nxt    = flags_r;
    cnt_nxt      = cnt_r;
    ok_nxt       = ok_r;
    lost_nxt     = lost_r;

    if (fire && !is_slot) begin
      in_round_nxt = head.send_ok;
      if (!head.send_ok) begin
        seq_nxt = seq_r + SEQ_W'(1);
      end else begin
        slot_nxt  = '0;
        flags_nxt = '0;
        cnt_nxt   = '0;
      end
    end else if (slot_step) begin
      flags_nxt = flags_upd;
      cnt_nxt   = cnt_upd;
      slot_nxt  = slot_upd;
      if (closing) begin
        ok_nxt       = ok_r + TOTAL_W'(answered);
        lost_nxt     = lost_r + TOTAL_W'(!answered);
        seq_nxt      = seq_r + SEQ_W'(1);
        in_round_nxt = 1'b0;
        slot_nxt     = '0;
      end
    end

    out_valid_nxt = (emit && fire) || (out_valid_r && !out_ready);

    result_nxt.round_seq   = seq_r;
    result_nxt.poll_stamp  = poll_r;
    result_nxt.final_stamp = {1'b0, base_r, {BASE_LSB{1'b0}}} +
                             FINAL_W'(cfg.antenna_delay);
    result_nxt.ok_rounds   = ok_r + TOTAL_W'(answered);
    result_nxt.lost_rounds = lost_r + TOTAL_W'(!answered);
    for (int i = 0; i < ANCHORS; i++) begin
      result_nxt.slot_addr[i] = flags_upd[i] ? cfg.anchor_id[i] : '0;
      result_nxt.slot_rx[i]   = !flags_upd[i] ? '0 : (gain[i] ? head.rx_time : rx_r[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r       <= '0;
      in_round_r  <= 1'b0;
      slot_r      <= '0;
      flags_r     <= '0;
      cnt_r       <= '0;
      ok_r        <= '0;
      lost_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      seq_r       <= seq_nxt;
      in_round_r  <= in_round_nxt;
      slot_r      <= slot_nxt;
      flags_r     <= flags_nxt;
      cnt_r       <= cnt_nxt;
      ok_r        <= ok_nxt;
      lost_r      <= lost_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start_round) begin
      poll_r <= head.poll_time;
      base_r <= head.final_base;
    end
    for (int i = 0; i < ANCHORS; i++) begin
      if (slot_step && gain[i]) begin
        rx_r[i] <= head.rx_time;
      end
    end
    if (emit && fire) begin
      result_r <= result_nxt;
    end
  end

endmodule

// File: sv/uwb_ranging_initiator_round.sv
// Top level of the UWB two-way ranging initiator round.
//
// Channels: in_ch takes poll and slot events, out_ch gives one final record
// per completed round, cfg_ch writes the seven configuration registers
// (always ready, a write takes effect at the next edge).
// An event is accepted when valid and ready are high at a rising edge. The
// front end classifies it in that cycle and puts it in a QUEUE_DEPTH entry
// queue; the back end retires one queued event per cycle while no closing
// slot waits on a stalled output. Throughput: one event per cycle sustained
// while out_ch does not stall and QUEUE_DEPTH is above one. A closing slot
// event is queued, and its final record registered, before out_ch shows it.
// The record waits in an output register; while it is not taken the back end
// still retires events that close no round, and holds at the next closing
// slot. in_ch.ready falls only when the queue is full.
// Reset (rst_n low at a clock edge) clears the config registers, the sequence
// number, both round counters, the queue and output valid. No clearing pass.
module uwb_ranging_initiator_round import uwbr_pkg::*; #(
  parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst_n,
  uwbr_in_if.sink    in_ch,
  uwbr_out_if.source out_ch,
  uwbr_cfg_if.sink   cfg_ch
);

  cfg_t     cfg;
  logic     q_push;
  q_entry_t q_push_entry;
  logic     q_full;
  logic     q_pop;
  logic     q_head_valid;
  q_entry_t q_head;
  logic     res_valid;
  result_t  res;

  uwbr_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  uwbr_front u_front (
    .in_ch (in_ch),
    .cfg   (cfg),
    .full  (q_full),
    .push  (q_push),
    .entry (q_push_entry)
  );

  uwbr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_entry (q_push_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head       (q_head)
  );

  uwbr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .head_valid (q_head_valid),
    .head       (q_head),
    .pop        (q_pop),
    .out_ready  (out_ch.ready),
    .out_valid  (res_valid),
    .result     (res)
  );

  assign out_ch.valid       = res_valid;
  assign out_ch.round_seq   = res.round_seq;
  assign out_ch.poll_stamp  = res.poll_stamp;
  assign out_ch.final_stamp = res.final_stamp;
  assign out_ch.slot1_addr  = res.slot_addr[0];
  assign out_ch.slot1_rx    = res.slot_rx[0];
  assign out_ch.slot2_addr  = res.slot_addr[1];
  assign out_ch.slot2_rx    = res.slot_rx[1];
  assign out_ch.slot3_addr  = res.slot_addr[2];
  assign out_ch.slot3_rx    = res.slot_rx[2];
  assign out_ch.ok_rounds   = res.ok_rounds;
  assign out_ch.lost_rounds = res.lost_rounds;

endmodule

// File: sv/uwbr_checker.sv
// Port-level checker of the final record channel, bound to the top level.
module uwbr_checker import uwbr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  uwbr_out_if.source out_ch
);

  logic [TOTAL_W-1:0] last_ok_r;
  logic [TOTAL_W-1:0] last_lost_r;
  logic               out_txn;

  assign out_txn = out_ch.valid && out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_ok_r   <= '0;
      last_lost_r <= '0;
    end else if (out_txn) begin
      last_ok_r   <= out_ch.ok_rounds;
      last_lost_r <= out_ch.lost_rounds;
    end
  end

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_ch.valid)
    else $error("output valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |=>
      out_ch.valid && $stable(out_ch.round_seq) && $stable(out_ch.final_stamp) &&
      $stable(out_ch.ok_rounds) && $stable(out_ch.lost_rounds))
    else $error("stalled record changed");

  a_one_counter: assert property (@(posedge clk) disable iff (!rst_n)
    out_txn |->
      (out_ch.ok_rounds == last_ok_r + 32'd1 && out_ch.lost_rounds == last_lost_r) ||
      (out_ch.ok_rounds == last_ok_r && out_ch.lost_rounds == last_lost_r + 32'd1))
    else $error("round counters did not advance by one");

  a_lost_empty: assert property (@(posedge clk) disable iff (!rst_n)
    out_txn && out_ch.lost_rounds != last_lost_r |->
      out_ch.slot1_addr == '0 && out_ch.slot1_rx == '0 &&
      out_ch.slot2_addr == '0 && out_ch.slot2_rx == '0 &&
      out_ch.slot3_addr == '0 && out_ch.slot3_rx == '0)
    else $error("lost round shows an answer");

endmodule

bind uwb_ranging_initiator_round uwbr_checker u_checker (
  .clk    (clk),
  .rst_n  (rst_n),
  .out_ch (out_ch)
);

// File: tb/testbench.sv
// Self-checking testbench of the UWB ranging initiator round.
`timescale 1ns / 1ps

module testbench;
  import uwbr_pkg::*;

  localparam logic [1:0] RX_UNDEFINED = 2'd3;
  localparam int DRAIN_CYCLES = 8;
  localparam int DRAIN_LIMIT  = 20000;
  localparam int LONG_HOLD    = 300;

  typedef struct packed {
    cmd_t              cmd;
    logic              send_ok;
    logic [TS_W-1:0]   poll_time;
    logic [1:0]        rx_status;
    logic              long_enough;
    logic [KIND_W-1:0] kind;
    logic [SEQ_W-1:0]  seq;
    logic [ADDR_W-1:0] dest;
    logic [ADDR_W-1:0] source;
    logic [TS_W-1:0]   rx_time;
  } event_t;

  class final_record_predictor;
    logic [ADDR_W-1:0]  my_addr;
    logic [ADDR_W-1:0]  anchor [ANCHORS];
    logic [KIND_W-1:0]  resp_kind;
    logic [TS_W-1:0]    final_delay;
    logic [ADDR_W-1:0]  ant_delay;
    logic [SEQ_W-1:0]   seq_ctr;
    bit                 in_round;
    int                 slot_idx;
    int                 answers;
    logic [ANCHORS-1:0] answered;
    logic [TS_W-1:0]    poll_held;
    logic [TS_W-1:0]    rx_held [ANCHORS];
    logic [TOTAL_W-1:0] ok_cnt;
    logic [TOTAL_W-1:0] lost_cnt;
    result_t            due_finals [$];
    int                 errors;

    function new();
      my_addr     = '0;
      resp_kind   = '0;
      final_delay = '0;
      ant_delay   = '0;
      seq_ctr     = '0;
      in_round    = 0;
      slot_idx    = 0;
      answers     = 0;
      answered    = '0;
      poll_held   = '0;
      ok_cnt      = '0;
      lost_cnt    = '0;
      errors      = 0;
      for (int i = 0; i < ANCHORS; i++) begin
        anchor[i]  = '0;
        rx_held[i] = '0;
      end
    endfunction

    function void set_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] v);
      case (idx)
        REG_MY_ADDRESS:    my_addr     = v[ADDR_W-1:0];
        REG_ANCHOR_ONE:    anchor[0]   = v[ADDR_W-1:0];
        REG_ANCHOR_TWO:    anchor[1]   = v[ADDR_W-1:0];
        REG_ANCHOR_THREE:  anchor[2]   = v[ADDR_W-1:0];
        REG_RESPONSE_TYPE: resp_kind   = v[KIND_W-1:0];
        REG_FINAL_DELAY:   final_delay = v[TS_W-1:0];
        REG_ANTENNA_DELAY: ant_delay   = v[ADDR_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_event(event_t ev);
      result_t        r;
      int             idx;
      logic [TS_W:0]  sum;
      if (ev.cmd == CMD_POLL) begin
        in_round = 0;
        if (!ev.send_ok) begin
          seq_ctr++;
          return;
        end
        in_round  = 1;
        poll_held = ev.poll_time;
        slot_idx  = 0;
        answered  = '0;
        answers   = 0;
        for (int i = 0; i < ANCHORS; i++) rx_held[i] = '0;
        return;
      end
      if (!in_round) return;
      if (ev.rx_status == RX_FRAME && ev.long_enough && ev.kind == resp_kind &&
          ev.seq == seq_ctr && ev.dest == my_addr) begin
        idx = -1;
        for (int i = ANCHORS - 1; i >= 0; i--) if (anchor[i] == ev.source) idx = i;
        if (idx >= 0 && !answered[idx]) begin
          rx_held[idx]  = ev.rx_time;
          answered[idx] = 1'b1;
          answers++;
        end
      end
      slot_idx++;
      if (slot_idx < ANCHORS && answers < ANCHORS) return;
      if (answers > 0) ok_cnt++;
      else lost_cnt++;
      sum = {1'b0, poll_held} + {1'b0, final_delay};
      r.round_seq   = seq_ctr;
      r.poll_stamp  = poll_held;
      r.final_stamp = {1'b0, sum[TS_W-1:BASE_LSB], {BASE_LSB{1'b0}}} +
                      FINAL_W'(ant_delay);
      for (int i = 0; i < ANCHORS; i++) begin
        r.slot_addr[i] = answered[i] ? anchor[i] : '0;
        r.slot_rx[i]   = answered[i] ? rx_held[i] : '0;
      end
      r.ok_rounds   = ok_cnt;
      r.lost_rounds = lost_cnt;
      due_finals.push_back(r);
      seq_ctr++;
      in_round = 0;
      slot_idx = 0;
    endfunction

    function void compare(string name, logic [63:0] want, logic [63:0] got);
      if (want !== got) begin
        $display("%0t: %s expected %h got %h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_final(result_t got);
      result_t want;
      if (due_finals.size() == 0) begin
        $display("%0t: final record with none expected, round_seq got %h", $time,
                 got.round_seq);
        errors++;
        return;
      end
      want = due_finals.pop_front();
      compare("round_seq", 64'(want.round_seq), 64'(got.round_seq));
      compare("poll_stamp", 64'(want.poll_stamp), 64'(got.poll_stamp));
      compare("final_stamp", 64'(want.final_stamp), 64'(got.final_stamp));
      for (int i = 0; i < ANCHORS; i++) begin
        compare($sformatf("slot%0d_addr", i + 1), 64'(want.slot_addr[i]),
                64'(got.slot_addr[i]));
        compare($sformatf("slot%0d_rx", i + 1), 64'(want.slot_rx[i]),
                64'(got.slot_rx[i]));
      end
      compare("ok_rounds", 64'(want.ok_rounds), 64'(got.ok_rounds));
      compare("lost_rounds", 64'(want.lost_rounds), 64'(got.lost_rounds));
    endfunction
  endclass

  logic clk;
  logic rst_n;

  uwbr_in_if  in_ch ();
  uwbr_out_if out_ch ();
  uwbr_cfg_if cfg_ch ();

  uwb_ranging_initiator_round dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  final_record_predictor pred = new();

  int tx_max_gap    = 3;
  int rx_max_stall  = 3;
  bit hold_request  = 0;
  int useful_events = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [TS_W-1:0] rand_ts();
    logic [63:0] w;
    w = {$urandom, $urandom};
    return w[TS_W-1:0];
  endfunction

  function automatic event_t random_event();
    event_t ev;
    ev.cmd         = cmd_t'(1'($urandom_range(0, 1)));
    ev.send_ok     = 1'($urandom_range(0, 1));
    ev.poll_time   = rand_ts();
    ev.rx_status   = 2'($urandom_range(0, 3));
    ev.long_enough = 1'($urandom_range(0, 1));
    ev.kind        = KIND_W'($urandom);
    ev.seq         = SEQ_W'($urandom);
    ev.dest        = ADDR_W'($urandom);
    ev.source      = ADDR_W'($urandom);
    ev.rx_time     = rand_ts();
    return ev;
  endfunction

  function automatic event_t poll_event(bit ok, logic [TS_W-1:0] ts);
    event_t ev;
    ev           = random_event();
    ev.cmd       = CMD_POLL;
    ev.send_ok   = ok;
    ev.poll_time = ts;
    return ev;
  endfunction

  function automatic event_t answer_event(int idx);
    event_t ev;
    ev             = random_event();
    ev.cmd         = CMD_SLOT;
    ev.rx_status   = RX_FRAME;
    ev.long_enough = 1'b1;
    ev.kind        = pred.resp_kind;
    ev.seq         = pred.seq_ctr;
    ev.dest        = pred.my_addr;
    ev.source      = pred.anchor[idx];
    return ev;
  endfunction

  function automatic event_t broken_answer();
    event_t ev;
    ev = answer_event($urandom_range(0, ANCHORS - 1));
    case ($urandom_range(0, 5))
      0: ev.long_enough = 1'b0;
      1: ev.kind = ev.kind ^ KIND_W'($urandom_range(1, 255));
      2: ev.seq = ev.seq ^ SEQ_W'($urandom_range(1, 255));
      3: ev.dest = ev.dest ^ ADDR_W'($urandom_range(1, 65535));
      4: ev.source = ADDR_W'($urandom);
      default: ev.rx_status = 2'($urandom_range(1, 3));
    endcase
    return ev;
  endfunction

  function automatic event_t slot_event();
    event_t ev;
    int     c;
    c = $urandom_range(0, 99);
    if (c < 55) return answer_event($urandom_range(0, ANCHORS - 1));
    if (c < 70) return broken_answer();
    ev     = random_event();
    ev.cmd = CMD_SLOT;
    if (c < 80) ev.rx_status = RX_TIMEOUT;
    else if (c < 87) ev.rx_status = RX_ERROR;
    else if (c < 90) ev.rx_status = RX_UNDEFINED;
    return ev;
  endfunction

  task automatic send_event(input event_t ev);
    int gap;
    gap = $urandom_range(0, tx_max_gap);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.cmd               <= ev.cmd;
    in_ch.send_ok           <= ev.send_ok;
    in_ch.poll_time         <= ev.poll_time;
    in_ch.rx_status         <= ev.rx_status;
    in_ch.frame_long_enough <= ev.long_enough;
    in_ch.msg_kind          <= ev.kind;
    in_ch.msg_seq           <= ev.seq;
    in_ch.msg_dest          <= ev.dest;
    in_ch.msg_source        <= ev.source;
    in_ch.rx_time           <= ev.rx_time;
    in_ch.valid             <= 1'b1;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    if (ev.cmd == CMD_POLL || pred.in_round) useful_events++;
    pred.note_event(ev);
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] v);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= v;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    pred.set_reg(idx, v);
  endtask

  task automatic program_regs(input logic [CFG_DATA_W-1:0] my, a1, a2, a3, kind, dly, ant);
    write_reg(REG_MY_ADDRESS, my);
    write_reg(REG_ANCHOR_ONE, a1);
    write_reg(REG_ANCHOR_TWO, a2);
    write_reg(REG_ANCHOR_THREE, a3);
    write_reg(REG_RESPONSE_TYPE, kind);
    write_reg(REG_FINAL_DELAY, dly);
    write_reg(REG_ANTENNA_DELAY, ant);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // drop valid, wait for every due record, then let the queue run dry
  task automatic settle();
    int waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    while (pred.due_finals.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pred.due_finals.size() != 0) begin
      $display("%0t: %0d final records never arrived", $time, pred.due_finals.size());
      pred.errors += pred.due_finals.size();
      pred.due_finals.delete();
    end
  endtask

  task automatic run_rounds(input int budget);
    int target;
    int pick;
    event_t ev;
    target = useful_events + budget;
    while (useful_events < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        ev     = random_event();
        ev.cmd = CMD_SLOT;
        send_event(ev);
      end else if (pick < 12) begin
        send_event(poll_event(1'b0, rand_ts()));
      end else begin
        send_event(poll_event(1'b1, rand_ts()));
        for (int s = 0; s < ANCHORS; s++) begin
          if ($urandom_range(0, 99) < 5) break;
          send_event(slot_event());
        end
      end
    end
    // close any open round before the registers change
    send_event(poll_event(1'b0, rand_ts()));
  endtask

  initial begin
    result_t got;
    int      stall;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 0;
        stall = LONG_HOLD;
      end else begin
        stall = $urandom_range(0, rx_max_stall);
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (out_ch.valid !== 1'b1);
      got.round_seq    = out_ch.round_seq;
      got.poll_stamp   = out_ch.poll_stamp;
      got.final_stamp  = out_ch.final_stamp;
      got.slot_addr[0] = out_ch.slot1_addr;
      got.slot_rx[0]   = out_ch.slot1_rx;
      got.slot_addr[1] = out_ch.slot2_addr;
      got.slot_rx[1]   = out_ch.slot2_rx;
      got.slot_addr[2] = out_ch.slot3_addr;
      got.slot_rx[2]   = out_ch.slot3_rx;
      got.ok_rounds    = out_ch.ok_rounds;
      got.lost_rounds  = out_ch.lost_rounds;
      pred.check_final(got);
    end
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    event_t ev;
    logic [CFG_DATA_W-1:0] a1;
    rst_n                   <= 1'b0;
    in_ch.valid             <= 1'b0;
    in_ch.cmd               <= CMD_POLL;
    in_ch.send_ok           <= 1'b0;
    in_ch.poll_time         <= '0;
    in_ch.rx_status         <= RX_FRAME;
    in_ch.frame_long_enough <= 1'b0;
    in_ch.msg_kind          <= '0;
    in_ch.msg_seq           <= '0;
    in_ch.msg_dest          <= '0;
    in_ch.msg_source        <= '0;
    in_ch.rx_time           <= '0;
    cfg_ch.valid            <= 1'b0;
    cfg_ch.index            <= REG_MY_ADDRESS;
    cfg_ch.data             <= '0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: all anchors at address 0, so duplicates resolve to slot one
    send_event(answer_event(0));
    send_event(poll_event(1'b0, '0));
    send_event(poll_event(1'b1, {TS_W{1'b1}}));
    send_event(answer_event(1));
    send_event(answer_event(2));
    ev = random_event();
    ev.cmd = CMD_SLOT;
    ev.rx_status = RX_TIMEOUT;
    send_event(ev);
    settle();

    program_regs(40'hFF_FFFF_FFFF, 40'h1, 40'h8000, 40'hFFFF, 40'hFF,
                 {CFG_DATA_W{1'b1}}, 40'hFFFF);
    send_event(poll_event(1'b1, '0));
    send_event(answer_event(2));
    send_event(answer_event(0));
    send_event(answer_event(1));

    send_event(poll_event(1'b1, rand_ts()));
    ev = answer_event(0);
    ev.long_enough = 1'b0;
    send_event(ev);
    ev = answer_event(1);
    ev.rx_status = RX_UNDEFINED;
    send_event(ev);
    ev = answer_event(2);
    ev.rx_status = RX_ERROR;
    send_event(ev);

    send_event(poll_event(1'b1, rand_ts()));
    send_event(answer_event(1));
    send_event(poll_event(1'b1, rand_ts()));
    ev = answer_event(0);
    ev.seq = ev.seq + 1'b1;
    send_event(ev);
    ev = answer_event(1);
    ev.dest = ev.dest ^ 16'h0001;
    send_event(ev);
    ev = answer_event(2);
    ev.kind = ev.kind ^ 8'h80;
    send_event(ev);

    send_event(poll_event(1'b1, {TS_W{1'b1}}));
    ev = answer_event(0);
    ev.source = 16'h0002;
    send_event(ev);
    send_event(answer_event(0));
    send_event(answer_event(0));
    settle();

    for (int p = 0; p < 6; p++) begin
      tx_max_gap   = (p == 1 || p == 3 || p == 5) ? 0 : 16;
      rx_max_stall = (p == 1 || p == 2) ? 0 : 16;
      case (p)
        1: program_regs('0, '0, '0, '0, '0, '0, '0);
        2: program_regs({CFG_DATA_W{1'b1}}, {CFG_DATA_W{1'b1}}, {CFG_DATA_W{1'b1}},
                        {CFG_DATA_W{1'b1}}, {CFG_DATA_W{1'b1}}, {CFG_DATA_W{1'b1}},
                        {CFG_DATA_W{1'b1}});
        3: begin
          a1 = rand_ts();
          program_regs(rand_ts(), a1, a1, rand_ts(), rand_ts(), rand_ts(), rand_ts());
        end
        default: program_regs(rand_ts(), rand_ts(), rand_ts(), rand_ts(), rand_ts(),
                              rand_ts(), rand_ts());
      endcase
      if (p == 5) hold_request = 1;
      run_rounds(310);
      settle();
    end

    if (pred.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: sim.f
sv/uwbr_pkg.sv
sv/uwbr_if.sv
sv/uwbr_cfg_regs.sv
sv/uwbr_front.sv
sv/uwbr_queue.sv
sv/uwbr_back.sv
sv/uwb_ranging_initiator_round.sv
sv/uwbr_checker.sv
tb/testbench.sv
